// ----- hdl/bopp_pkg.sv -----
`timescale 1ns / 1ps
// bopp_pkg: shared types, constants and helpers of the barrier option path block
// no dependencies; used by every module in hdl
package bopp_pkg;

    localparam int STEP_W    = 13;
    localparam int MAX_STEPS = 4096;

    // ln 2 in q.24 and its scaled reciprocal, floor(2^36 / ln2_q24)
    localparam logic [23:0] LN2_Q24   = 24'd11629080;
    localparam logic [12:0] RECIP_LN2 = 13'd5909;

    // exponent window: outside [-33 ln2, 32 ln2) the result is flat
    localparam logic [6:0]         K_OFS = 7'd33;
    localparam logic signed [37:0] X_HI  = 38'sd372130560;
    localparam logic signed [37:0] X_LO  = -38'sd383759640;
    localparam logic [29:0]        X_OFS = 30'd383759640;

    localparam logic [3:0]  LAST_TERM = 4'd11;
    localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
    localparam logic [31:0] PRICE_MAX = 32'hFFFF_FFFF;

    // item kinds
    localparam logic KIND_STEP = 1'b0;
    localparam logic KIND_FLAT = 1'b1;

    // register indexes
    localparam logic [2:0] CFG_START   = 3'd0;
    localparam logic [2:0] CFG_STRIKE  = 3'd1;
    localparam logic [2:0] CFG_BARRIER = 3'd2;
    localparam logic [2:0] CFG_DRIFT   = 3'd3;
    localparam logic [2:0] CFG_VOL     = 3'd4;
    localparam logic [2:0] CFG_HORIZON = 3'd5;
    localparam logic [2:0] CFG_STEPS   = 3'd6;

    typedef struct packed {
        logic [31:0]        start_price;
        logic [31:0]        strike_price;
        logic [31:0]        barrier_level;
        logic signed [15:0] drift_spread;
        logic [15:0]        volatility;
        logic [15:0]        time_horizon;
        logic [STEP_W-1:0]  step_count;
    } t_cfg;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] shock;
        logic signed [15:0] rate;
    } t_item;

    // step count capped at the largest path length
    function automatic logic [STEP_W-1:0] eff_steps(input logic [STEP_W-1:0] sc);
        eff_steps = (sc > STEP_W'(MAX_STEPS)) ? STEP_W'(MAX_STEPS) : sc;
    endfunction

    function automatic logic [31:0] intrinsic(input logic [31:0] p, input logic [31:0] k);
        intrinsic = (p > k) ? (p - k) : 32'd0;
    endfunction

    // floor((2^32 - 1) / n) for the taylor divisors
    function automatic logic [31:0] term_recip(input logic [3:0] n);
        case (n)
            4'd1:    term_recip = 32'hFFFF_FFFF;
            4'd2:    term_recip = 32'h7FFF_FFFF;
            4'd3:    term_recip = 32'h5555_5555;
            4'd4:    term_recip = 32'h3FFF_FFFF;
            4'd5:    term_recip = 32'h3333_3333;
            4'd6:    term_recip = 32'h2AAA_AAAA;
            4'd7:    term_recip = 32'h2492_4924;
            4'd8:    term_recip = 32'h1FFF_FFFF;
            4'd9:    term_recip = 32'h1C71_C71C;
            4'd10:   term_recip = 32'h1999_9999;
            4'd11:   term_recip = 32'h1745_D174;
            default: term_recip = 32'h0000_0000;
        endcase
    endfunction

endpackage

// ----- hdl/bopp_front.sv -----
`timescale 1ns / 1ps
// bopp_front: input register stage, tags each item as a path step or a flat item
// depends on bopp_pkg
module bopp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_shock,
    input  logic signed [15:0] i_rate,
    input  bopp_pkg::t_cfg     i_cfg,
    output logic               o_q_valid,
    input  logic               i_q_ready,
    output bopp_pkg::t_item    o_q_item
);
    import bopp_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign o_in_ready = !r_valid || i_q_ready;
    assign o_q_valid  = r_valid;
    assign o_q_item   = r_item;

    // classify: no steps means the item only yields the start intrinsic
    always_comb begin
        n_item.kind  = (eff_steps(i_cfg.step_count) == '0) ? KIND_FLAT : KIND_STEP;
        n_item.shock = i_shock;
        n_item.rate  = i_rate;
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= n_item;
        end
    end

endmodule

// ----- hdl/bopp_queue.sv -----
`timescale 1ns / 1ps
// bopp_queue: two-entry item queue between front and back
// depends on bopp_pkg
module bopp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  bopp_pkg::t_item i_push_item,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output bopp_pkg::t_item o_pop_item
);
    import bopp_pkg::*;

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_item   = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_item;
        end
    end

endmodule

// ----- hdl/bopp_back.sv -----
`timescale 1ns / 1ps
// bopp_back: path sequencer - path setup (divide, square root), per-step exponential
// and price update, payoff result; depends on bopp_pkg
module bopp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bopp_pkg::t_cfg  i_cfg,
    input  logic            i_q_valid,
    output logic            o_q_ready,
    input  bopp_pkg::t_item i_q_item,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    output logic [31:0]     o_res_payoff,
    output logic            o_res_knocked_out
);
    import bopp_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIV   = 4'd1;
    localparam logic [3:0] S_SQRT  = 4'd2;
    localparam logic [3:0] S_SCALE = 4'd3;
    localparam logic [3:0] S_COEF  = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_SUM   = 4'd6;
    localparam logic [3:0] S_REC   = 4'd7;
    localparam logic [3:0] S_KR    = 4'd8;
    localparam logic [3:0] S_KFIX  = 4'd9;
    localparam logic [3:0] S_TMUL  = 4'd10;
    localparam logic [3:0] S_TREC  = 4'd11;
    localparam logic [3:0] S_TFIX  = 4'd12;
    localparam logic [3:0] S_PROD  = 4'd13;
    localparam logic [3:0] S_SHIFT = 4'd14;
    localparam logic [3:0] S_EMIT  = 4'd15;

    localparam logic [1:0] CLS_MID = 2'd0;
    localparam logic [1:0] CLS_HI  = 2'd1;
    localparam logic [1:0] CLS_LO  = 2'd2;

    // control
    logic [3:0]        r_state;
    logic [STEP_W-1:0] r_step_index;
    logic              r_hit;
    logic [3:0]        r_tn;

    // item and path state
    logic signed [15:0] r_shock;
    logic signed [15:0] r_rate;
    logic [31:0]        r_step_len;
    logic [31:0]        r_svol;
    logic [30:0]        r_hvar;
    logic [31:0]        r_price;

    // setup units
    logic [31:0] r_dq;
    logic [12:0] r_rem;
    logic [4:0]  r_cnt;
    logic [39:0] r_sq_v;
    logic [39:0] r_root;
    logic [39:0] r_bit;

    // step datapath
    logic               r_c_neg;
    logic [31:0]        r_c_mag;
    logic               r_s_neg;
    logic [15:0]        r_s_mag;
    logic [63:0]        r_pd;
    logic [47:0]        r_pv;
    logic [1:0]         r_cls;
    logic [29:0]        r_u;
    logic [42:0]        r_kq;
    logic [29:0]        r_r;
    logic [6:0]         r_k;
    logic [29:0]        r_r30;
    logic signed [7:0]  r_ks;
    logic [30:0]        r_term;
    logic [31:0]        r_sum;
    logic [30:0]        r_tv;
    logic [30:0]        r_qe;
    logic [63:0]        r_prod;
    logic [31:0]        r_payoff;
    logic               r_ko;

    // combinational helpers
    logic [STEP_W-1:0]  steps;
    logic [13:0]        div_t;
    logic               div_ge;
    logic [31:0]        div_q;
    logic [40:0]        sq_sum;
    logic               sq_ge;
    logic signed [16:0] rs;
    logic signed [33:0] coef;
    logic [33:0]        coef_abs;
    logic signed [37:0] d_term;
    logic signed [37:0] v_term;
    logic signed [37:0] xs;
    logic [37:0]        xu;
    logic [30:0]        k_lin;
    logic [30:0]        r_diff;
    logic               kf_ge;
    logic [29:0]        kf_r;
    logic [6:0]         kf_k;
    logic [60:0]        t_prod;
    logic [62:0]        q_prod;
    logic [34:0]        q_back;
    logic [34:0]        q_rem;
    logic [30:0]        q_fix;
    logic [7:0]         sh_amt;
    logic [63:0]        sh_right;
    logic [33:0]        p_hi;
    logic [4:0]         k_pos;
    logic [31:0]        n_price;
    logic               n_hit;
    logic [STEP_W-1:0]  n_idx;

    assign steps             = eff_steps(i_cfg.step_count);
    assign o_q_ready         = (r_state == S_IDLE);
    assign o_res_valid       = (r_state == S_EMIT);
    assign o_res_payoff      = r_payoff;
    assign o_res_knocked_out = r_ko;

    // divider and square root steps
    always_comb begin
        div_t  = {r_rem, r_dq[31]};
        div_ge = (div_t >= {1'b0, steps});
        div_q  = {r_dq[30:0], div_ge};
        sq_sum = {1'b0, r_root} + {1'b0, r_bit};
        sq_ge  = ({1'b0, r_sq_v} >= sq_sum);
    end

    // drift coefficient and exponent argument
    always_comb begin
        rs       = 17'(r_rate) + 17'(i_cfg.drift_spread);
        coef     = {{4{rs[16]}}, rs, 13'd0} - $signed({3'd0, r_hvar});
        coef_abs = coef[33] ? 34'(-coef) : 34'(coef);
        d_term   = $signed({2'd0, r_pd[63:28]});
        v_term   = $signed({2'd0, r_pv[47:12]});
        xs       = (r_c_neg ? -d_term : d_term) + (r_s_neg ? -v_term : v_term);
        xu       = 38'(xs + $signed({8'd0, X_OFS}));
    end

    // range reduction and taylor division by the term index
    always_comb begin
        k_lin  = 31'(r_kq[42:36] * LN2_Q24);
        r_diff = {1'b0, r_u} - k_lin;
        kf_ge  = (r_r >= {6'd0, LN2_Q24});
        kf_r   = kf_ge ? (r_r - {6'd0, LN2_Q24}) : r_r;
        kf_k   = kf_ge ? (r_k + 7'd1) : r_k;
        t_prod = r_term * r_r30;
        q_prod = r_tv * term_recip(r_tn);
        q_back = 35'(r_qe * r_tn);
        q_rem  = {4'd0, r_tv} - q_back;
        q_fix  = (q_rem >= {31'd0, r_tn}) ? (r_qe + 31'd1) : r_qe;
    end

    // new price: scale by 2^k with saturation
    always_comb begin
        sh_amt   = 8'(8'sd30 - r_ks);
        sh_right = r_prod >> sh_amt[5:0];
        p_hi     = r_prod[63:30];
        k_pos    = r_ks[4:0];
        case (r_cls)
            CLS_HI:  n_price = (r_price == 32'd0) ? 32'd0 : PRICE_MAX;
            CLS_LO:  n_price = 32'd0;
            default: begin
                if (r_ks[7]) begin
                    n_price = (sh_right[63:32] != 32'd0) ? PRICE_MAX : sh_right[31:0];
                end else if (p_hi == 34'd0) begin
                    n_price = 32'd0;
                end else if (p_hi[33:32] != 2'd0 || p_hi[31:0] > (PRICE_MAX >> k_pos)) begin
                    n_price = PRICE_MAX;
                end else begin
                    n_price = p_hi[31:0] << k_pos;
                end
            end
        endcase
        n_hit = r_hit || (n_price >= i_cfg.barrier_level);
        n_idx = r_step_index + STEP_W'(1);
    end

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_step_index <= '0;
            r_hit        <= 1'b0;
            r_tn         <= 4'd1;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        if (i_q_item.kind == KIND_FLAT) begin
                            r_state <= S_EMIT;
                        end else if (r_step_index == '0) begin
                            r_state <= S_DIV;
                        end else begin
                            r_state <= S_COEF;
                        end
                    end
                end
                S_DIV: begin
                    if (r_cnt == 5'd31) r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (r_bit[0]) r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_hit   <= 1'b0;
                    r_state <= S_COEF;
                end
                S_COEF:  r_state <= S_MUL;
                S_MUL:   r_state <= S_SUM;
                S_SUM:   r_state <= (xs >= X_HI || xs < X_LO) ? S_SHIFT : S_REC;
                S_REC:   r_state <= S_KR;
                S_KR:    r_state <= S_KFIX;
                S_KFIX: begin
                    r_tn    <= 4'd1;
                    r_state <= S_TMUL;
                end
                S_TMUL:  r_state <= S_TREC;
                S_TREC:  r_state <= S_TFIX;
                S_TFIX: begin
                    if (r_tn == LAST_TERM) begin
                        r_state <= S_PROD;
                    end else begin
                        r_tn    <= r_tn + 4'd1;
                        r_state <= S_TMUL;
                    end
                end
                S_PROD:  r_state <= S_SHIFT;
                S_SHIFT: begin
                    r_hit <= n_hit;
                    if (n_idx >= steps) begin
                        r_step_index <= '0;
                        r_state      <= S_EMIT;
                    end else begin
                        r_step_index <= n_idx;
                        r_state      <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (i_res_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_shock  <= i_q_item.shock;
                r_rate   <= i_q_item.rate;
                r_payoff <= intrinsic(i_cfg.start_price, i_cfg.strike_price);
                r_ko     <= 1'b0;
                r_dq     <= {i_cfg.time_horizon, 16'd0};
                r_rem    <= 13'd0;
                r_cnt    <= 5'd0;
            end
            S_DIV: begin
                r_rem      <= div_ge ? 13'(div_t - {1'b0, steps}) : div_t[12:0];
                r_dq       <= div_q;
                r_cnt      <= r_cnt + 5'd1;
                r_step_len <= div_q;
                r_sq_v     <= {div_q, 8'd0};
                r_root     <= 40'd0;
                r_bit      <= 40'h40_0000_0000;
            end
            S_SQRT: begin
                if (sq_ge) begin
                    r_sq_v <= r_sq_v - sq_sum[39:0];
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            S_SCALE: begin
                r_svol  <= 32'((36'(i_cfg.volatility) * 36'(r_root[19:0])) >> 6);
                r_hvar  <= 31'((32'(i_cfg.volatility) * 32'(i_cfg.volatility)) >> 1);
                r_price <= i_cfg.start_price;
            end
            S_COEF: begin
                r_c_neg <= coef[33];
                r_c_mag <= coef_abs[31:0];
                r_s_neg <= r_shock[15];
                r_s_mag <= r_shock[15] ? 16'(-r_shock) : 16'(r_shock);
            end
            S_MUL: begin
                r_pd <= r_c_mag * r_step_len;
                r_pv <= r_svol * r_s_mag;
            end
            S_SUM: begin
                r_cls <= (xs >= X_HI) ? CLS_HI : ((xs < X_LO) ? CLS_LO : CLS_MID);
                r_u   <= xu[29:0];
            end
            S_REC: r_kq <= r_u * RECIP_LN2;
            S_KR: begin
                r_r <= r_diff[29:0];
                r_k <= r_kq[42:36];
            end
            S_KFIX: begin
                r_r30  <= {kf_r[23:0], 6'd0};
                r_ks   <= $signed({1'b0, kf_k}) - $signed({1'b0, K_OFS});
                r_term <= ONE_Q30;
                r_sum  <= {1'b0, ONE_Q30};
            end
            S_TMUL: r_tv <= t_prod[60:30];
            S_TREC: r_qe <= q_prod[62:32];
            S_TFIX: begin
                r_term <= q_fix;
                r_sum  <= r_sum + {1'b0, q_fix};
            end
            S_PROD: r_prod <= r_price * r_sum;
            S_SHIFT: begin
                r_price  <= n_price;
                r_payoff <= n_hit ? 32'd0 : intrinsic(n_price, i_cfg.strike_price);
                r_ko     <= n_hit;
            end
            default: r_payoff <= r_payoff;
        endcase
    end

`ifndef ASSERT_OFF
    a_ko_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res_knocked_out) |-> (o_res_payoff == 32'd0))
        else $error("knocked-out result with nonzero payoff");

    a_mid_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_ready && i_q_valid && i_q_item.kind == KIND_STEP && r_step_index != '0)
        |=> (r_state == S_COEF))
        else $error("mid-path step did not skip path setup");

    a_term_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TFIX) |-> (r_tn >= 4'd1 && r_tn <= LAST_TERM))
        else $error("taylor term index out of range");

    a_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCALE) |-> ((r_root[19:0] * r_root[19:0]) <= {r_step_len, 8'd0}))
        else $error("square root too large");
`endif

endmodule

// ----- hdl/barrier_option_path_payoff.sv -----
`timescale 1ns / 1ps
// barrier_option_path_payoff: top level - register file, front stage, queue, back
// sequencer and result register; depends on bopp_pkg, bopp_front, bopp_queue, bopp_back
//
// channel  direction  handshake                  payload
// in       input      i_in_valid / o_in_ready    i_shock, i_rate
// out      output     o_out_valid / i_out_ready  o_payoff, o_knocked_out
// cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// a path step runs the back sequencer through coefficient, multiply, sum, range
// reduction, eleven taylor terms (multiply, reciprocal, fix) and product to shift;
// outside the exponent window it goes from sum straight to shift. a path's first step
// adds 32 divide steps, 20 root steps and one scale; its last step ends in the emit
// state, which a flat item (step count zero) enters directly. the front and queue
// hold three items; synchronous active-low reset; config writes are always accepted
module barrier_option_path_payoff (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_shock,
    input  logic signed [15:0] i_rate,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [31:0]        o_payoff,
    output logic               o_knocked_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import bopp_pkg::*;

    t_cfg        r_cfg;
    logic        r_out_valid;
    logic [31:0] r_payoff;
    logic        r_ko;
    logic        fq_valid;
    logic        fq_ready;
    t_item       fq_item;
    logic        qb_valid;
    logic        qb_ready;
    t_item       qb_item;
    logic        res_valid;
    logic        res_ready;
    logic [31:0] res_payoff;
    logic        res_ko;

    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_payoff      = r_payoff;
    assign o_knocked_out = r_ko;
    assign res_ready     = !r_out_valid || i_out_ready;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_price   <= 32'd6553600;
            r_cfg.strike_price  <= 32'd6553600;
            r_cfg.barrier_level <= 32'd7864320;
            r_cfg.drift_spread  <= 16'sd0;
            r_cfg.volatility    <= 16'd3277;
            r_cfg.time_horizon  <= 16'd256;
            r_cfg.step_count    <= STEP_W'(252);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_START:   r_cfg.start_price   <= i_cfg_data;
                CFG_STRIKE:  r_cfg.strike_price  <= i_cfg_data;
                CFG_BARRIER: r_cfg.barrier_level <= i_cfg_data;
                CFG_DRIFT:   r_cfg.drift_spread  <= $signed(i_cfg_data[15:0]);
                CFG_VOL:     r_cfg.volatility    <= i_cfg_data[15:0];
                CFG_HORIZON: r_cfg.time_horizon  <= i_cfg_data[15:0];
                CFG_STEPS:   r_cfg.step_count    <= i_cfg_data[STEP_W-1:0];
                default:     r_cfg               <= r_cfg;
            endcase
        end
    end

    bopp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_shock    (i_shock),
        .i_rate     (i_rate),
        .i_cfg      (r_cfg),
        .o_q_valid  (fq_valid),
        .i_q_ready  (fq_ready),
        .o_q_item   (fq_item)
    );

    bopp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fq_valid),
        .o_push_ready (fq_ready),
        .i_push_item  (fq_item),
        .o_pop_valid  (qb_valid),
        .i_pop_ready  (qb_ready),
        .o_pop_item   (qb_item)
    );

    bopp_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_q_valid         (qb_valid),
        .o_q_ready         (qb_ready),
        .i_q_item          (qb_item),
        .o_res_valid       (res_valid),
        .i_res_ready       (res_ready),
        .o_res_payoff      (res_payoff),
        .o_res_knocked_out (res_ko)
    );

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_payoff <= res_payoff;
            r_ko     <= res_ko;
        end
    end

endmodule

// ----- test/tb_barrier_option_path_payoff.sv -----
`timescale 1ns / 1ps
// tb_barrier_option_path_payoff: self-checking bench for the barrier option path block,
// a directed table then random paths, checked against the table's expected values
// or an in-bench price path model; depends on bopp_pkg and barrier_option_path_payoff
module tb_barrier_option_path_payoff;
    import bopp_pkg::*;

    localparam longint LN2 = 64'sd11629080;
    localparam int     SETTLE = 400;

    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [2:0]  idx;
        logic [31:0] data;
        logic [15:0] shock;
        logic [15:0] rate;
        bit          typed;
        logic [31:0] want_payoff;
        logic        want_ko;
    } t_row;

    typedef struct {
        logic [31:0] payoff;
        logic        ko;
    } t_payoff;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic signed [15:0] i_shock = '0;
    logic signed [15:0] i_rate = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [31:0]        o_payoff;
    logic               o_knocked_out;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;

    barrier_option_path_payoff dut (.*);

    always #5 i_clk = ~i_clk;

    // model copy of registers and path state
    logic [31:0] m_start, m_strike, m_barrier, m_price;
    logic [15:0] m_drift, m_vol, m_horizon;
    logic [12:0] m_steps, m_index;
    logic        m_hit;
    logic [31:0] m_dt, m_sigdt, m_halfvar;

    t_payoff pending_payoffs[$];
    t_row    plan[$];
    int      errors = 0;
    bit      quiet_in = 1'b0;
    bit      quiet_out = 1'b0;
    int      out_stall = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // price times exp(x), x signed q.24, saturating q16.16
    function automatic logic [31:0] grow_price(input logic [31:0] price, input longint x);
        longint          k, r, sh;
        longint unsigned r30, term, sum, prod, p;
        k = x / LN2;
        r = x - k * LN2;
        if (r < 0) begin
            r += LN2;
            k--;
        end
        r30 = longint'(r) << 6;
        term = 64'd1 << 30;
        sum = term;
        for (int n = 1; n < 12; n++) begin
            term = ((term * r30) >> 30) / n;
            sum += term;
        end
        prod = longint'({32'd0, price}) * sum;
        if (k < 0) begin
            sh = 30 - k;
            if (sh >= 64) return 32'd0;
            p = prod >> sh;
            return (p > 64'hFFFF_FFFF) ? PRICE_MAX : p[31:0];
        end
        p = prod >> 30;
        if (p == 0) return 32'd0;
        if (p > 64'hFFFF_FFFF || k >= 32 || p > (64'hFFFF_FFFF >> k)) return PRICE_MAX;
        return 32'(p << k);
    endfunction

    function automatic logic [31:0] above_strike(input logic [31:0] p);
        return (p > m_strike) ? p - m_strike : 32'd0;
    endfunction

    // advance the path by one item; returns 1 when a payoff is due
    function automatic bit advance_path(input logic signed [15:0] shock,
                                        input logic signed [15:0] rate,
                                        output t_payoff res);
        logic [12:0]     n;
        longint          coef, drift, vterm;
        longint unsigned mag;
        n = (m_steps > 13'd4096) ? 13'd4096 : m_steps;
        if (n == 0) begin
            res.payoff = above_strike(m_start);
            res.ko = 1'b0;
            return 1'b1;
        end
        if (m_index == 0) begin
            m_dt = 32'(({48'd0, m_horizon} << 16) / n);
            m_sigdt = 32'((longint'({48'd0, m_vol}) * int_sqrt({32'd0, m_dt} << 8)) >> 6);
            m_halfvar = 32'((longint'({48'd0, m_vol}) * m_vol) >> 1);
            m_price = m_start;
            m_hit = 1'b0;
        end
        coef = (longint'(rate) + longint'($signed(m_drift))) * 8192 - longint'({32'd0, m_halfvar});
        mag = (coef < 0) ? -coef : coef;
        drift = longint'((mag * m_dt) >> 28);
        if (coef < 0) drift = -drift;
        mag = (shock < 0) ? -longint'(shock) : longint'(shock);
        vterm = longint'((longint'({32'd0, m_sigdt}) * mag) >> 12);
        if (shock < 0) vterm = -vterm;
        m_price = grow_price(m_price, drift + vterm);
        if (m_price >= m_barrier) m_hit = 1'b1;
        m_index = m_index + 13'd1;
        if (m_index >= n) begin
            m_index = '0;
            res.payoff = m_hit ? 32'd0 : above_strike(m_price);
            res.ko = m_hit;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int pick_gap(input bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // hold the sender until every payoff is in and the back end has drained
    task automatic drain;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_payoffs.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_START:   m_start = data;
            CFG_STRIKE:  m_strike = data;
            CFG_BARRIER: m_barrier = data;
            CFG_DRIFT:   m_drift = data[15:0];
            CFG_VOL:     m_vol = data[15:0];
            CFG_HORIZON: m_horizon = data[15:0];
            CFG_STEPS:   m_steps = data[12:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_item(input logic [15:0] shock, input logic [15:0] rate,
                             input bit typed, input t_payoff want);
        int      gap;
        t_payoff res;
        gap = pick_gap(quiet_in);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_shock <= shock;
        i_rate <= rate;
        do @(posedge i_clk); while (!o_in_ready);
        if (advance_path(shock, rate, res)) pending_payoffs.push_back(typed ? want : res);
    endtask

    function automatic void add_cfg(input logic [2:0] idx, input logic [31:0] data);
        plan.push_back('{ROW_CFG, idx, data, 16'd0, 16'd0, 1'b0, 32'd0, 1'b0});
    endfunction

    function automatic void add_item(input logic [15:0] s, input logic [15:0] r,
                                     input bit typed = 0, input logic [31:0] p = 0,
                                     input logic ko = 0);
        plan.push_back('{ROW_ITEM, 3'd0, 32'd0, s, r, typed, p, ko});
    endfunction

    // result side: random stalls and in-order compare
    always @(posedge i_clk) begin
        t_payoff want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_payoffs.size() == 0) begin
                    report_mismatch("unexpected payoff", o_payoff, 32'd0);
                end else begin
                    want = pending_payoffs.pop_front();
                    if (o_payoff !== want.payoff)
                        report_mismatch("payoff", o_payoff, want.payoff);
                    if (o_knocked_out !== want.ko)
                        report_mismatch("knocked_out", o_knocked_out, want.ko);
                end
            end
            if (out_stall > 0) begin
                i_out_ready <= 1'b0;
                out_stall <= out_stall - 1;
            end else begin
                i_out_ready <= 1'b1;
                out_stall <= pick_gap(quiet_out);
            end
        end
    end

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int      sent, burst, n;
        t_payoff want;
        logic [15:0] s, r;
        m_start = 32'd6553600;
        m_strike = 32'd6553600;
        m_barrier = 32'd7864320;
        m_drift = '0;
        m_vol = 16'd3277;
        m_horizon = 16'd256;
        m_steps = 13'd252;
        m_price = '0;
        m_hit = 1'b0;
        m_index = '0;
        m_dt = '0;
        m_sigdt = '0;
        m_halfvar = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // no steps: intrinsic of the start price, at reset values then extremes
        add_cfg(CFG_STEPS, 32'd0);
        add_item(16'h0000, 16'h0000, 1, 32'd0, 1'b0);
        add_item(16'h7FFF, 16'h8000, 1, 32'd0, 1'b0);
        add_cfg(CFG_START, 32'd13107200);
        add_item(16'h8000, 16'h7FFF, 1, 32'd6553600, 1'b0);
        add_cfg(CFG_START, 32'hFFFF_FFFF);
        add_cfg(CFG_STRIKE, 32'd0);
        add_item(16'hFFFF, 16'hFFFF, 1, 32'hFFFF_FFFF, 1'b0);
        // barrier at zero always knocks out
        add_cfg(CFG_START, 32'd6553600);
        add_cfg(CFG_STRIKE, 32'd6553600);
        add_cfg(CFG_BARRIER, 32'd0);
        add_cfg(CFG_STEPS, 32'd1);
        add_item(16'h0000, 16'h0000, 1, 32'd0, 1'b1);
        // field extremes, saturation and underflow of the price
        add_cfg(CFG_BARRIER, 32'hFFFF_FFFF);
        add_cfg(CFG_VOL, 32'hFFFF);
        add_cfg(CFG_HORIZON, 32'hFFFF);
        add_item(16'h7FFF, 16'h7FFF);
        add_item(16'h8000, 16'h8000);
        add_item(16'h0001, 16'hFFFF);
        add_cfg(CFG_DRIFT, 32'h8000);
        add_cfg(CFG_HORIZON, 32'd0);
        add_item(16'hFFFF, 16'h0001);
        add_cfg(CFG_DRIFT, 32'h7FFF);
        add_cfg(CFG_HORIZON, 32'd256);
        add_cfg(CFG_VOL, 32'd3277);
        add_cfg(CFG_STEPS, 32'd4);
        add_item(16'h1000, 16'h0000);
        add_item(16'hF000, 16'h0100);
        add_item(16'h0800, 16'h0000);
        add_item(16'h0000, 16'h0000);
        // step count above the cap, then cut short mid path
        add_cfg(CFG_STEPS, 32'h1FFF);
        add_item(16'h0400, 16'h0000);
        add_item(16'hFC00, 16'h0000);
        add_item(16'h0200, 16'h0000);
        add_cfg(CFG_STEPS, 32'd2);
        add_item(16'h0100, 16'h0000);
        add_cfg(CFG_STEPS, 32'd4096);
        add_item(16'h0100, 16'h0000);
        add_cfg(CFG_STEPS, 32'd1);
        add_item(16'h0100, 16'h0000);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                drain();
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                want.payoff = plan[i].want_payoff;
                want.ko = plan[i].want_ko;
                send_item(plan[i].shock, plan[i].rate, plan[i].typed, want);
            end
        end

        // random phases: fresh settings, then a run of paths
        sent = 0;
        while (sent < 400) begin
            drain();
            quiet_in = ($urandom_range(0, 3) == 0);
            quiet_out = ($urandom_range(0, 3) == 0);
            n = $urandom_range(0, 19);
            write_reg(CFG_START, (n == 0) ? $urandom() : (n == 1) ? 32'd0 :
                      32'($urandom_range(50, 150)) << 16);
            n = $urandom_range(0, 19);
            write_reg(CFG_STRIKE, (n == 0) ? $urandom() : (n == 1) ? PRICE_MAX :
                      32'($urandom_range(60, 140)) << 16);
            n = $urandom_range(0, 19);
            write_reg(CFG_BARRIER, (n == 0) ? 32'd0 : (n == 1) ? $urandom() :
                      (n < 5) ? PRICE_MAX : m_start + (32'($urandom_range(0, 40)) << 16));
            n = $urandom_range(0, 9);
            write_reg(CFG_DRIFT, (n == 0) ? 32'($urandom_range(0, 65535)) :
                      32'($urandom_range(0, 2000)) - 32'd1000);
            n = $urandom_range(0, 9);
            write_reg(CFG_VOL, (n == 0) ? 32'($urandom_range(0, 65535)) :
                      32'($urandom_range(0, 8000)));
            n = $urandom_range(0, 9);
            write_reg(CFG_HORIZON, (n == 0) ? 32'($urandom_range(0, 65535)) :
                      32'($urandom_range(16, 1024)));
            n = $urandom_range(0, 19);
            write_reg(CFG_STEPS, (n < 2) ? 32'd0 : (n == 2) ? 32'($urandom_range(0, 8191)) :
                      32'($urandom_range(1, 6)));
            burst = (m_steps == 0 || m_steps > 6) ? $urandom_range(5, 30) :
                    m_steps * $urandom_range(1, 4);
            want = '{32'd0, 1'b0};
            repeat (burst) begin
                n = $urandom_range(0, 9);
                s = (n == 0) ? 16'($urandom()) : 16'($urandom_range(0, 8191) - 4096);
                r = (n == 1) ? 16'($urandom()) : (n < 5) ? 16'd0 :
                    16'($urandom_range(0, 1600) - 800);
                send_item(s, r, 1'b0, want);
                sent++;
            end
        end

        drain();
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
